FILE: src/tap_changer_relay_controller_unit_assert.svh
// ----------------------------------------------------------------------------
// Tap changer assertion macros
// Concurrent checks, sampled on the rising clock, off while reset is low.
// ----------------------------------------------------------------------------
`ifndef TAP_CHANGER_RELAY_CONTROLLER_UNIT_ASSERT_SVH
`define TAP_CHANGER_RELAY_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication
`define TCR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/tcr_pkg.sv
// ----------------------------------------------------------------------------
// Tap changer package
// Widths, band limits, codes and state types shared by the controller files.
// ----------------------------------------------------------------------------
package tcr_pkg;

  localparam int unsigned VOLT_W     = 12;
  localparam int unsigned CDN_W      = 8;
  localparam int unsigned MS_W       = 32;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned FAULT_W    = 2;
  localparam int unsigned TAPS_W     = 3;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - (TAPS_W + 1 + MODE_W + FAULT_W + 1 + CDN_W);

  localparam logic [MS_W-1:0] TICK_MS = 32'd1000;

  // mode selection bands, upper bounds exclusive unless noted
  localparam logic [VOLT_W-1:0] BAND4_LO  = 12'd2100;
  localparam logic [VOLT_W-1:0] BAND4_HI  = 12'd2800; // inclusive
  localparam logic [VOLT_W-1:0] BAND1_LO  = 12'd1800;
  localparam logic [VOLT_W-1:0] BAND1_HI  = 12'd2050;
  localparam logic [VOLT_W-1:0] BAND2_LO  = 12'd1540;
  localparam logic [VOLT_W-1:0] BAND2_HI  = 12'd1700;
  localparam logic [VOLT_W-1:0] BAND3_LO  = 12'd1300;
  localparam logic [VOLT_W-1:0] BAND3_HI  = 12'd1480;
  localparam logic [VOLT_W-1:0] ENG2_LO   = 12'd1500;
  localparam logic [VOLT_W-1:0] ENG3_LO   = 12'd1200;
  localparam logic [VOLT_W-1:0] ENG_FLOOR = 12'd1200;

  localparam logic [MODE_W-1:0] MODE_NONE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ONE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TWO   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_THREE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FOUR  = 3'd4;

  localparam logic [TAPS_W-1:0] TAPS_ALL   = 3'b111;
  localparam logic [TAPS_W-1:0] TAPS_TWO   = 3'b110;
  localparam logic [TAPS_W-1:0] TAPS_THREE = 3'b100;
  localparam logic [TAPS_W-1:0] TAPS_NONE  = 3'b000;

  localparam logic [FAULT_W-1:0] FAULT_NONE  = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_UNDER = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_OVER  = 2'd2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_LOW_LIMIT  = 3'd0,
    REG_HIGH_LIMIT = 3'd1,
    REG_START_MIN  = 3'd2,
    REG_START_MAX  = 3'd3,
    REG_COUNTDOWN  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [VOLT_W-1:0] low_limit;
    logic [VOLT_W-1:0] high_limit;
    logic [VOLT_W-1:0] start_min;
    logic [VOLT_W-1:0] start_max;
    logic [CDN_W-1:0]  countdown;
  } tcr_cfg_t;

  typedef struct packed {
    logic [TAPS_W-1:0] taps;      // bit0 tap one .. bit2 tap three
    logic              load;
    logic [MODE_W-1:0] mode;
    logic              waiting;
    logic              counting;
    logic [CDN_W-1:0]  seconds;
    logic [MS_W-1:0]   last_tick;
  } tcr_state_t;

  localparam tcr_cfg_t CFG_RESET = '{
    low_limit:  12'd1200,
    high_limit: 12'd2750,
    start_min:  12'd1300,
    start_max:  12'd2700,
    countdown:  8'd10
  };

  localparam tcr_state_t STATE_RESET = '{
    taps:      TAPS_ALL,
    load:      1'b1,
    mode:      MODE_NONE,
    waiting:   1'b1,
    counting:  1'b0,
    seconds:   8'd10,
    last_tick: 32'd0
  };

endpackage

FILE: src/tcr_pass.sv
// ----------------------------------------------------------------------------
// Tap changer control pass
// Next state and fault code for one item, from the present state and config.
// ----------------------------------------------------------------------------
module tcr_pass import tcr_pkg::*; (
  input  tcr_cfg_t           cfg_i,
  input  tcr_state_t         state_i,
  input  logic [VOLT_W-1:0]  in_volt_i,
  input  logic [VOLT_W-1:0]  out_volt_i,
  input  logic [MS_W-1:0]    now_ms_i,
  output tcr_state_t         state_o,
  output logic [FAULT_W-1:0] fault_o
);

  logic              under_v;
  logic              over_v;
  logic [MS_W-1:0]   elapsed;
  tcr_state_t        st;
  logic [FAULT_W-1:0] fault;

  assign under_v = in_volt_i < cfg_i.low_limit;
  assign over_v  = (in_volt_i > cfg_i.high_limit) || (out_volt_i > cfg_i.high_limit);

  always_comb begin
    st    = state_i;
    fault = FAULT_NONE;

    // cut-off: everything high, countdown re-armed
    if (under_v || over_v) begin
      st.load      = 1'b1;
      st.taps      = TAPS_ALL;
      st.last_tick = '0;
      st.seconds   = cfg_i.countdown;
      st.mode      = MODE_ONE;
      st.waiting   = 1'b1;
      st.counting  = 1'b0;
    end
    if (over_v) begin
      fault = FAULT_OVER;
    end else if (under_v) begin
      fault = FAULT_UNDER;
    end

    if (st.waiting && !st.counting) begin
      if (in_volt_i >= cfg_i.start_min && in_volt_i < cfg_i.start_max) begin
        st.load     = 1'b1;
        st.taps     = TAPS_ALL;
        st.counting = 1'b1;
      end else if (in_volt_i > cfg_i.start_max) begin
        st.load     = 1'b1;
        st.counting = 1'b0;
      end
    end

    // bands are disjoint; a voltage in a gap keeps the mode
    if (in_volt_i >= BAND4_LO && in_volt_i <= BAND4_HI) st.mode = MODE_FOUR;
    if (in_volt_i >= BAND1_LO && in_volt_i <  BAND1_HI) st.mode = MODE_ONE;
    if (in_volt_i >= BAND2_LO && in_volt_i <  BAND2_HI) st.mode = MODE_TWO;
    if (in_volt_i >= BAND3_LO && in_volt_i <  BAND3_HI) st.mode = MODE_THREE;

    if (!st.waiting && !st.counting) begin
      case (st.mode)
        MODE_ONE:   begin st.taps = TAPS_ALL;   st.load = 1'b0; end
        MODE_TWO:   begin st.taps = TAPS_TWO;   st.load = 1'b0; end
        MODE_THREE: begin st.taps = TAPS_THREE; st.load = 1'b0; end
        MODE_FOUR:  begin st.taps = TAPS_NONE;  st.load = 1'b1; end
        default:    ;
      endcase
    end

    elapsed = now_ms_i - st.last_tick;
    if (st.counting && elapsed >= TICK_MS) begin
      st.last_tick = now_ms_i;
      if (st.seconds != '0) begin
        st.seconds = st.seconds - CDN_W'(1);
      end else if (in_volt_i > ENG_FLOOR && in_volt_i <= cfg_i.start_max) begin
        // engage a tap
        st.last_tick = '0;
        st.seconds   = cfg_i.countdown;
        st.counting  = 1'b0;
        st.waiting   = 1'b0;
        if (in_volt_i >= BAND1_LO && in_volt_i < BAND1_HI) begin
          st.mode = MODE_ONE;   st.taps = TAPS_ALL;
        end
        if (in_volt_i >= ENG2_LO && in_volt_i < BAND1_LO) begin
          st.mode = MODE_TWO;   st.taps = TAPS_TWO;
        end
        if (in_volt_i >= ENG3_LO && in_volt_i < ENG2_LO) begin
          st.mode = MODE_THREE; st.taps = TAPS_THREE;
        end
        if (in_volt_i >= BAND1_HI && in_volt_i < cfg_i.start_max) begin
          st.mode = MODE_FOUR;  st.taps = TAPS_NONE;
        end
      end else if (in_volt_i > cfg_i.start_max) begin
        st.load      = 1'b1;
        st.last_tick = '0;
        st.seconds   = cfg_i.countdown;
        st.counting  = 1'b1;
        st.waiting   = 1'b1;
      end
      // at or below the engage floor nothing moves; the next tick retries
    end
  end

  assign state_o = st;
  assign fault_o = fault;

endmodule

FILE: src/tap_changer_relay_controller_unit.sv
// A result item appears on the master side in the cycle after its item is accepted.
// Throughput: one item per cycle; the whole pass is one combinational step into the
// state and result registers. A waiting result holds the input off until the cycle it is taken.
// Reset (rst_ni low, asynchronous): config back to its defaults, relays all high, no mode,
// countdown armed at ten seconds, output register empty.
// ----------------------------------------------------------------------------
// Tap changer relay controller
// Control state, config registers and result register around the control pass.
// ----------------------------------------------------------------------------
module tap_changer_relay_controller_unit import tcr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [VOLT_W-1:0]     cfg_data_i,
  // input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // in_volt, out_volt, now_ms
  // result items
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata   // tap_one, tap_two, tap_three,
                                               // load_relay, tap_mode, fault,
                                               // counting, seconds_left, pad
);

  `include "tap_changer_relay_controller_unit_assert.svh"

  tcr_cfg_t              cfg_q;
  tcr_state_t            state_q, state_d;
  logic [FAULT_W-1:0]    fault;
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic                  in_accept;
  logic                  cfg_accept;

  logic [VOLT_W-1:0] in_volt;
  logic [VOLT_W-1:0] out_volt;
  logic [MS_W-1:0]   now_ms;

  assign in_volt  = s_axis_tdata[VOLT_W-1:0];
  assign out_volt = s_axis_tdata[2*VOLT_W-1:VOLT_W];
  assign now_ms   = s_axis_tdata[2*VOLT_W+MS_W-1:2*VOLT_W];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign cfg_accept    = cfg_valid_i && cfg_ready_o;

  tcr_pass u_pass (
    .cfg_i      (cfg_q),
    .state_i    (state_q),
    .in_volt_i  (in_volt),
    .out_volt_i (out_volt),
    .now_ms_i   (now_ms),
    .state_o    (state_d),
    .fault_o    (fault)
  );

  assign out_data_d = {{OUT_PAD_W{1'b0}}, state_d.seconds, state_d.counting, fault,
                       state_d.mode, state_d.load, state_d.taps};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_accept) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_LOW_LIMIT:  cfg_q.low_limit  <= cfg_data_i;
        REG_HIGH_LIMIT: cfg_q.high_limit <= cfg_data_i;
        REG_START_MIN:  cfg_q.start_min  <= cfg_data_i;
        REG_START_MAX:  cfg_q.start_max  <= cfg_data_i;
        REG_COUNTDOWN:  cfg_q.countdown  <= cfg_data_i[CDN_W-1:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= STATE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        state_q <= state_d;
      end
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `TCR_ASSERT_NOW(a_count_implies_wait, clk_i, rst_ni, state_q.counting,
    state_q.waiting, "countdown running without the wait flag")
  `TCR_ASSERT_NEXT(a_accept_fills_out, clk_i, rst_ni, in_accept,
    m_axis_tvalid, "accepted item produced no result")
  `TCR_ASSERT_NEXT(a_state_only_on_accept, clk_i, rst_ni, !in_accept,
    $stable(state_q), "control state moved without an item")
  `TCR_ASSERT_NEXT(a_mode_stays_chosen, clk_i, rst_ni, state_q.mode != MODE_NONE,
    state_q.mode != MODE_NONE, "tap mode fell back to none")

endmodule

FILE: tb/tb_tap_changer_relay_controller_unit.sv
// ----------------------------------------------------------------------------
// Tap changer relay controller testbench
// A directed table walks the fault, countdown, engage and mode-band cases, and
// then randomized control passes run under several register settings.
// Every result item is checked against an in-bench model of the control pass, or
// against its own expected word for a typed row. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_tap_changer_relay_controller_unit;
  import tcr_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_SHOWN   = 10;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_FIRST = 3'd5;

  typedef struct packed {
    logic [MS_W-1:0]   now_ms;
    logic [VOLT_W-1:0] out_volt;
    logic [VOLT_W-1:0] in_volt;
  } pass_in_t;

  typedef struct packed {
    logic [OUT_PAD_W-1:0] pad;
    logic [CDN_W-1:0]     seconds;
    logic                 counting;
    logic [FAULT_W-1:0]   fault;
    logic [MODE_W-1:0]    mode;
    logic                 load;
    logic [TAPS_W-1:0]    taps;
  } relay_res_t;

  typedef enum logic { ROW_PASS, ROW_WRITE } row_kind_e;

  typedef struct {
    row_kind_e               kind;
    logic [CFG_ADDR_W-1:0]   cfg_idx;
    logic [VOLT_W-1:0]       cfg_val;
    pass_in_t                pass;
    bit                      typed;
    relay_res_t              want;
  } plan_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [VOLT_W-1:0]     cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // in_volt, out_volt, now_ms
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // tap_one, tap_two, tap_three, load_relay,
                                         // tap_mode, fault, counting, seconds_left, pad

  tap_changer_relay_controller_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  tcr_cfg_t          ctl_cfg;
  tcr_state_t        ctl_st;
  relay_res_t        relay_exp_q[$];
  plan_row_t         plan_q[$];
  int                fail_count  = 0;
  int                cycle_count = 0;
  logic [MS_W-1:0]   clock_ms;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // control pass model
  // ---------------------------------------------------------------------------
  function automatic void trip_all();
    ctl_st.load      = 1'b1;
    ctl_st.taps      = TAPS_ALL;
    ctl_st.last_tick = '0;
    ctl_st.seconds   = ctl_cfg.countdown;
    ctl_st.mode      = MODE_ONE;
    ctl_st.waiting   = 1'b1;
    ctl_st.counting  = 1'b0;
  endfunction

  function automatic relay_res_t control_pass(input pass_in_t p);
    relay_res_t          r;
    logic [FAULT_W-1:0]  flt;
    logic [MS_W-1:0]     since;
    logic [VOLT_W-1:0]   v;
    v   = p.in_volt;
    flt = FAULT_NONE;
    if (v < ctl_cfg.low_limit) begin
      trip_all();
      flt = FAULT_UNDER;
    end
    // overvoltage wins when both apply
    if (v > ctl_cfg.high_limit || p.out_volt > ctl_cfg.high_limit) begin
      trip_all();
      flt = FAULT_OVER;
    end
    if (ctl_st.waiting && !ctl_st.counting) begin
      if (v >= ctl_cfg.start_min && v < ctl_cfg.start_max) begin
        ctl_st.load     = 1'b1;
        ctl_st.taps     = TAPS_ALL;
        ctl_st.counting = 1'b1;
      end else if (v > ctl_cfg.start_max) begin
        ctl_st.load     = 1'b1;
        ctl_st.counting = 1'b0;
      end
    end
    // bands with gaps: a voltage in a gap keeps the mode
    if (v >= BAND4_LO && v <= BAND4_HI) ctl_st.mode = MODE_FOUR;
    if (v >= BAND1_LO && v < BAND1_HI)  ctl_st.mode = MODE_ONE;
    if (v >= BAND2_LO && v < BAND2_HI)  ctl_st.mode = MODE_TWO;
    if (v >= BAND3_LO && v < BAND3_HI)  ctl_st.mode = MODE_THREE;
    if (!ctl_st.waiting && !ctl_st.counting) begin
      case (ctl_st.mode)
        MODE_ONE: begin
          ctl_st.taps = TAPS_ALL;
          ctl_st.load = 1'b0;
        end
        MODE_TWO: begin
          ctl_st.taps = TAPS_TWO;
          ctl_st.load = 1'b0;
        end
        MODE_THREE: begin
          ctl_st.taps = TAPS_THREE;
          ctl_st.load = 1'b0;
        end
        MODE_FOUR: begin
          ctl_st.taps = TAPS_NONE;
          ctl_st.load = 1'b1;
        end
        default: ;
      endcase
    end
    since = p.now_ms - ctl_st.last_tick;
    if (ctl_st.counting && since >= TICK_MS) begin
      ctl_st.last_tick = p.now_ms;
      if (ctl_st.seconds != '0) begin
        ctl_st.seconds = ctl_st.seconds - 1'b1;
      end else if (v > ENG_FLOOR && v <= ctl_cfg.start_max) begin
        ctl_st.last_tick = '0;
        ctl_st.seconds   = ctl_cfg.countdown;
        ctl_st.counting  = 1'b0;
        ctl_st.waiting   = 1'b0;
        if (v >= BAND1_LO && v < BAND1_HI) begin
          ctl_st.mode = MODE_ONE;
          ctl_st.taps = TAPS_ALL;
        end
        if (v >= ENG2_LO && v < BAND1_LO) begin
          ctl_st.mode = MODE_TWO;
          ctl_st.taps = TAPS_TWO;
        end
        if (v >= ENG3_LO && v < ENG2_LO) begin
          ctl_st.mode = MODE_THREE;
          ctl_st.taps = TAPS_THREE;
        end
        if (v >= BAND1_HI && v < ctl_cfg.start_max) begin
          ctl_st.mode = MODE_FOUR;
          ctl_st.taps = TAPS_NONE;
        end
      end else if (v > ctl_cfg.start_max) begin
        ctl_st.load      = 1'b1;
        ctl_st.last_tick = '0;
        ctl_st.seconds   = ctl_cfg.countdown;
        ctl_st.counting  = 1'b1;
        ctl_st.waiting   = 1'b1;
      end
      // input at or below the floor: nothing changes, engage retries next tick
    end
    r.pad      = '0;
    r.taps     = ctl_st.taps;
    r.load     = ctl_st.load;
    r.mode     = ctl_st.mode;
    r.fault    = flt;
    r.counting = ctl_st.counting;
    r.seconds  = ctl_st.seconds;
    return r;
  endfunction

  function automatic relay_res_t relay_word(input logic [TAPS_W-1:0] taps, input logic load,
                                            input logic [MODE_W-1:0] mode,
                                            input logic [FAULT_W-1:0] flt, input logic cnt,
                                            input logic [CDN_W-1:0] sec);
    relay_res_t r;
    r = '{pad: '0, seconds: sec, counting: cnt, fault: flt, mode: mode, load: load, taps: taps};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [MS_W-1:0] ms_step();
    if ($urandom_range(0, 6) == 0) return $urandom_range(0, TICK_MS - 1);
    return $urandom_range(TICK_MS, TICK_MS + 400);
  endfunction

  // voltage at or next to a band edge, a register value or an end of the range
  function automatic logic [VOLT_W-1:0] boundary_volt();
    logic [VOLT_W-1:0] marks [16];
    marks = '{BAND4_LO, BAND4_HI, BAND1_LO, BAND1_HI, BAND2_LO, BAND2_HI, BAND3_LO,
              BAND3_HI, ENG2_LO, ENG_FLOOR, ctl_cfg.low_limit, ctl_cfg.high_limit,
              ctl_cfg.start_min, ctl_cfg.start_max, '0, '1};
    return marks[$urandom_range(0, 15)] + VOLT_W'($urandom_range(0, 2)) - 1'b1;
  endfunction

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (relay_exp_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [VOLT_W-1:0] val);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_LOW_LIMIT:  ctl_cfg.low_limit  = val;
      REG_HIGH_LIMIT: ctl_cfg.high_limit = val;
      REG_START_MIN:  ctl_cfg.start_min  = val;
      REG_START_MAX:  ctl_cfg.start_max  = val;
      REG_COUNTDOWN:  ctl_cfg.countdown  = val[CDN_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(input tcr_cfg_t c);
    write_reg(REG_LOW_LIMIT, c.low_limit);
    write_reg(REG_HIGH_LIMIT, c.high_limit);
    write_reg(REG_START_MIN, c.start_min);
    write_reg(REG_START_MAX, c.start_max);
    // upper data bits must be dropped by the 8-bit register
    write_reg(REG_COUNTDOWN, {4'($urandom), c.countdown});
    for (int k = REG_SPARE_FIRST; k < 2 ** CFG_ADDR_W; k++)
      write_reg(k[CFG_ADDR_W-1:0], VOLT_W'($urandom));
  endtask

  task automatic send_pass(input pass_in_t p, input int gap, input bit typed,
                           input relay_res_t want);
    relay_res_t r;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    do @(posedge clk_i); while (!s_axis_tready);
    r = control_pass(p);
    relay_exp_q.push_back(typed ? want : r);
  endtask

  task automatic add_pass(input logic [VOLT_W-1:0] v, input logic [VOLT_W-1:0] o,
                          input logic [MS_W-1:0] t);
    plan_row_t row;
    row = '{kind: ROW_PASS, cfg_idx: '0, cfg_val: '0, pass: '{now_ms: t, out_volt: o, in_volt: v},
            typed: 1'b0, want: '0};
    plan_q.push_back(row);
  endtask

  task automatic add_pass_typed(input logic [VOLT_W-1:0] v, input logic [VOLT_W-1:0] o,
                                input logic [MS_W-1:0] t, input relay_res_t want);
    plan_row_t row;
    row = '{kind: ROW_PASS, cfg_idx: '0, cfg_val: '0, pass: '{now_ms: t, out_volt: o, in_volt: v},
            typed: 1'b1, want: want};
    plan_q.push_back(row);
  endtask

  task automatic add_write(input logic [CFG_ADDR_W-1:0] idx, input logic [VOLT_W-1:0] val);
    plan_row_t row;
    row = '{kind: ROW_WRITE, cfg_idx: idx, cfg_val: val, pass: '0, typed: 1'b0, want: '0};
    plan_q.push_back(row);
  endtask

  // random passes: mostly steady runs long enough to finish a countdown, some noise
  task automatic drive_phase(input int n_items);
    pass_in_t          p;
    int                sent;
    int                len;
    bit                calm;
    logic [VOLT_W-1:0] target;
    sent = 0;
    while (sent < n_items) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 75) begin
        target = VOLT_W'($urandom_range(ctl_cfg.start_min, ctl_cfg.start_max));
        len    = ctl_cfg.countdown + $urandom_range(2, 8);
        for (int k = 0; k < len && sent < n_items; k++) begin
          if ($urandom_range(0, 9) == 0) target = boundary_volt();
          clock_ms   = clock_ms + ms_step();
          p.in_volt  = target;
          p.out_volt = VOLT_W'($urandom_range(0, ctl_cfg.high_limit));
          p.now_ms   = clock_ms;
          send_pass(p, pick_gap(calm), 1'b0, '0);
          sent++;
        end
      end else begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len && sent < n_items; k++) begin
          if ($urandom_range(0, 3) == 0) clock_ms = $urandom;
          else clock_ms = clock_ms + ms_step();
          p.in_volt  = $urandom_range(0, 1) ? boundary_volt() : VOLT_W'($urandom);
          p.out_volt = $urandom_range(0, 1) ? boundary_volt() : VOLT_W'($urandom);
          p.now_ms   = clock_ms;
          send_pass(p, pick_gap(calm), 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random back-pressure and checking
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    bit calm;
    stall = 0;
    calm  = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 199) == 0) calm = !calm;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        stall = pick_gap(calm);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    relay_res_t got;
    relay_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (relay_exp_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN)
          $display("relay result with nothing pending: %h", got);
      end else begin
        want = relay_exp_q.pop_front();
        if (got.taps !== want.taps || got.load !== want.load || got.mode !== want.mode ||
            got.fault !== want.fault || got.counting !== want.counting ||
            got.seconds !== want.seconds || got.pad !== want.pad) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN)
            $display({"relay result wrong: exp taps=%b load=%b mode=%0d fault=%0d cnt=%b ",
                      "sec=%0d pad=%h / got taps=%b load=%b mode=%0d fault=%0d cnt=%b ",
                      "sec=%0d pad=%h"},
                     want.taps, want.load, want.mode, want.fault, want.counting,
                     want.seconds, want.pad, got.taps, got.load, got.mode, got.fault,
                     got.counting, got.seconds, got.pad);
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    tcr_cfg_t phase_cfg [6];
    int       phase_len [6];
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_addr_i    = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    ctl_cfg       = CFG_RESET;
    ctl_st        = STATE_RESET;
    clock_ms      = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // no mode chosen yet: count and engage in the band gaps, relays must hold
    add_write(REG_START_MAX, 12'd2060);
    add_write(REG_COUNTDOWN, 12'd1);
    for (int k = 1; k <= 10; k++) add_pass(12'd2055, 12'd0, 32'(k * TICK_MS));
    add_pass(12'd2060, 12'd0, 32'd11000);
    add_pass(12'd2080, 12'd0, 32'd11500);
    add_pass_typed(12'd0, 12'd0, 32'd12000,
                   relay_word(TAPS_ALL, 1'b1, MODE_ONE, FAULT_UNDER, 1'b0, 8'd1));
    add_write(REG_START_MAX, 12'd2700);
    add_pass_typed(12'd4095, 12'd0, 32'd12100,
                   relay_word(TAPS_ALL, 1'b1, MODE_ONE, FAULT_OVER, 1'b0, 8'd1));
    // under and over together reads as over
    add_pass_typed(12'd0, 12'd4095, '1,
                   relay_word(TAPS_ALL, 1'b1, MODE_ONE, FAULT_OVER, 1'b0, 8'd1));
    add_pass(12'd2200, 12'd2200, 32'd20000);  // start plus first tick
    add_pass(12'd2200, 12'd2200, 32'd21000);  // engage, mode four
    add_pass(12'd1900, 12'd2750, 32'd21100);
    add_pass(12'd1600, 12'd0, 32'd21200);
    add_pass(12'd1400, 12'd0, 32'd21300);
    add_pass(12'd2750, 12'd0, 32'd21400);
    add_pass(12'd1199, 12'd0, 32'd21500);
    add_pass(12'd1300, 12'd0, 32'd30000);
    add_pass(12'd2720, 12'd0, 32'd31000);     // engage above start_max re-arms
    add_pass(12'd1200, 12'd0, 32'd32000);
    add_pass(12'd1200, 12'd0, 32'd33000);     // engage at the floor does nothing
    add_pass(12'd1201, 12'd0, 32'd34000);
    foreach (plan_q[i]) begin
      if (plan_q[i].kind == ROW_WRITE)
        write_reg(plan_q[i].cfg_idx, plan_q[i].cfg_val);
      else
        send_pass(plan_q[i].pass, pick_gap(1'b0), plan_q[i].typed, plan_q[i].want);
    end

    phase_cfg[0] = CFG_RESET;
    phase_cfg[1] = '{low_limit: '0, high_limit: '1, start_min: '0, start_max: '1, countdown: '0};
    phase_cfg[2] = '{low_limit: '1, high_limit: '0, start_min: '1, start_max: '0, countdown: '1};
    phase_cfg[3] = '{low_limit: 12'd1200, high_limit: 12'd2750, start_min: 12'd1300,
                     start_max: 12'd2700, countdown: '1};
    phase_len    = '{340, 330, 180, 400, 350, 350};
    for (int ph = 0; ph < 6; ph++) begin
      if (ph >= 4) begin
        phase_cfg[ph].low_limit  = VOLT_W'($urandom_range(0, 1500));
        phase_cfg[ph].high_limit = VOLT_W'($urandom_range(2000, 4095));
        phase_cfg[ph].start_min  = VOLT_W'($urandom_range(1000, 1800));
        phase_cfg[ph].start_max  = VOLT_W'($urandom_range(1800, 4095));
        phase_cfg[ph].countdown  = CDN_W'($urandom_range(0, 4));
      end
      set_config(phase_cfg[ph]);
      // one phase starts just short of the timestamp wrap
      clock_ms = (ph == 1) ? '1 - MS_W'($urandom_range(0, 50000)) : $urandom;
      if (ph == 0) begin
        drive_phase(phase_len[ph] / 2);
        wait_idle();
        drive_phase(phase_len[ph] / 2);
      end else begin
        drive_phase(phase_len[ph]);
      end
    end

    wait_idle();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && relay_exp_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/tcr_pkg.sv
src/tcr_pass.sv
src/tap_changer_relay_controller_unit.sv
tb/tb_tap_changer_relay_controller_unit.sv
